### hdl/flashlight_button_ui_controller_top_assert.svh
// assertion macros for the flashlight ui controller checker
`ifndef FLASHLIGHT_BUTTON_UI_CONTROLLER_TOP_ASSERT_SVH
`define FLASHLIGHT_BUTTON_UI_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define FLBUI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flbui same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define FLBUI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flbui next-cycle check failed");

`endif

### hdl/flbui_pkg.sv
// types and constants shared by the flashlight ui controller files
package flbui_pkg;

    // event codes
    localparam logic [3:0] EV_PRESS1     = 4'd0;
    localparam logic [3:0] EV_RELEASE1   = 4'd1;
    localparam logic [3:0] EV_CLICK      = 4'd2;
    localparam logic [3:0] EV_PRESS2     = 4'd3;
    localparam logic [3:0] EV_CLICK2     = 4'd4;
    localparam logic [3:0] EV_CLICK3     = 4'd5;
    localparam logic [3:0] EV_CLICK4     = 4'd6;
    localparam logic [3:0] EV_HOLD       = 4'd7;
    localparam logic [3:0] EV_HOLD_REL   = 4'd8;
    localparam logic [3:0] EV_CLICK_HOLD = 4'd9;
    localparam logic [3:0] EV_HOT        = 4'd10;
    localparam logic [3:0] EV_COOL       = 4'd11;
    localparam logic [3:0] EV_LOW_VOLT   = 4'd12;

    // ui modes
    localparam logic [2:0] UI_OFF    = 3'd0;
    localparam logic [2:0] UI_STEADY = 3'd1;
    localparam logic [2:0] UI_STROBE = 3'd2;
    localparam logic [2:0] UI_BATT   = 3'd3;
    localparam logic [2:0] UI_TEMP   = 3'd4;

    // blink codes
    localparam logic [1:0] BLINK_NONE  = 2'd0;
    localparam logic [1:0] BLINK_SHORT = 2'd1;
    localparam logic [1:0] BLINK_LONG  = 2'd2;

    // register indexes
    localparam logic REG_BRIGHT_THRESHOLD = 1'b0;
    localparam logic REG_HOLD_DELAY       = 1'b1;

    // reset values
    localparam logic [7:0] RST_BRIGHT_THRESHOLD = 8'd65;
    localparam logic [7:0] RST_HOLD_DELAY       = 8'd24;
    localparam logic [7:0] RST_STROBE_WAIT      = 8'd67;
    localparam logic [7:0] STROBE_WAIT_MIN      = 8'd8;
    localparam logic [7:0] STROBE_WAIT_MAX      = 8'd255;

    localparam int ARG_W = 16;

    typedef struct packed {
        logic [3:0]       mode;
        logic [ARG_W-1:0] arg;
    } t_in;

    typedef struct packed {
        logic [7:0] level;
        logic [2:0] ui_mode;
        logic       handled;
        logic [1:0] blink;
        logic       strobe_kind;
        logic [7:0] strobe_period;
    } t_out;

endpackage

### hdl/flashlight_button_ui_controller_top.sv
// one-button flashlight ui mode machine with a bit-serial remainder unit
// an accepted event runs a serial remainder of arg by the ramp step, one bit per cycle,
// then updates state and loads the result register once the previous result has gone
// a new event is taken only after the last one has been committed
// reset: synchronous, active low; modes, levels, strobe settings and registers
// return to their power-on values and both channels empty
module flashlight_button_ui_controller_top
    import flbui_pkg::*;
#(
    parameter int MAX_BRIGHT = 150
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // event channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);

    localparam logic [7:0] MAX_LVL  = 8'(MAX_BRIGHT);
    localparam logic [7:0] LVL_DIV6 = 8'(MAX_BRIGHT / 6);
    localparam logic [7:0] LVL_DIV4 = 8'(MAX_BRIGHT / 4);
    localparam int         CNT_W    = $clog2(ARG_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC
    } t_state;

    t_state r_state;

    // sequencer and remainder unit
    logic [CNT_W-1:0] r_cnt;
    logic [ARG_W-1:0] r_shift;
    logic [7:0]       r_rem;
    t_in              r_in;

    // configuration registers
    logic [7:0] r_thr;
    logic [7:0] r_hold;

    // ui state
    logic [2:0] r_ui;
    logic [7:0] r_cur;
    logic [7:0] r_remem;
    logic [7:0] r_tt;
    logic [7:0] r_ramp;
    logic [7:0] r_sw;
    logic       r_ss;

    // result register
    logic r_out_valid;
    t_out r_out;

    // next values
    logic [2:0] n_ui;
    logic [7:0] n_cur;
    logic [7:0] n_remem;
    logic [7:0] n_tt;
    logic [7:0] n_ramp;
    logic [7:0] n_sw;
    logic       n_ss;
    logic       n_handled;
    logic [1:0] n_blink;

    logic [7:0] step;
    logic [8:0] rem_sh;
    logic [7:0] n_rem;
    logic       out_free;

    // steady entry and switch-off requests from the event decode
    logic       go_steady;
    logic [7:0] steady_lvl;
    logic       go_off;

    // arithmetic helpers
    logic [8:0]       up_sum;
    logic [7:0]       nl_ramp;
    logic [ARG_W:0]   hot_diff;
    logic [7:0]       nl_hot;
    logic [ARG_W:0]   cool_sum;
    logic [7:0]       nl_cool;

    assign step = (r_ramp == 8'd0) ? 8'd1 : r_ramp;

    // one restoring remainder step: shift in the next arg bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem, r_shift[ARG_W-1]};
        if (rem_sh >= {1'b0, step}) begin
            n_rem = 8'(rem_sh - {1'b0, step});
        end else begin
            n_rem = rem_sh[7:0];
        end
    end

    // the result register may be loaded when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        // ramp up saturates at the top level, ramp down stops at the lowest
        up_sum = {1'b0, r_cur} + {1'b0, step};
        if (r_in.mode == EV_HOLD) begin
            nl_ramp = (up_sum < {1'b0, MAX_LVL}) ? up_sum[7:0] : MAX_LVL;
        end else begin
            nl_ramp = (r_cur > step) ? 8'(r_cur - step) : 8'd1;
        end

        // thermal step-down saturates at zero then clamps to a quarter of full
        if ({{(ARG_W-8){1'b0}}, r_cur} > r_in.arg) begin
            hot_diff = {{(ARG_W-7){1'b0}}, r_cur} - {1'b0, r_in.arg};
        end else begin
            hot_diff = '0;
        end
        nl_hot = (hot_diff[7:0] < LVL_DIV4) ? LVL_DIV4 : hot_diff[7:0];

        // thermal step-up by half the amount, capped at the target
        cool_sum = {{(ARG_W-7){1'b0}}, r_cur} + {2'b00, r_in.arg[ARG_W-1:1]};
        nl_cool  = (cool_sum > {{(ARG_W-7){1'b0}}, r_tt}) ? r_tt : cool_sum[7:0];
    end

    // event decode per mode
    always_comb begin
        n_ui       = r_ui;
        n_cur      = r_cur;
        n_remem    = r_remem;
        n_tt       = r_tt;
        n_ramp     = r_ramp;
        n_sw       = r_sw;
        n_ss       = r_ss;
        n_handled  = 1'b0;
        n_blink    = BLINK_NONE;
        go_steady  = 1'b0;
        steady_lvl = '0;
        go_off     = 1'b0;

        if (r_in.mode == EV_LOW_VOLT) begin
            // low voltage is taken in every mode
            n_handled = 1'b1;
            if (r_ui == UI_STROBE) begin
                go_steady  = 1'b1;
                steady_lvl = LVL_DIV6;
            end else if (r_ui == UI_STEADY) begin
                if (r_cur > 8'd1) begin
                    n_cur = {1'b0, r_cur[7:1]};
                end else begin
                    go_off = 1'b1;
                end
            end else begin
                go_off = 1'b1;
            end
        end else begin
            unique case (r_ui)
                UI_OFF: begin
                    n_handled = 1'b1;
                    case (r_in.mode)
                        EV_PRESS1:   n_cur = 8'd1;
                        EV_RELEASE1: n_cur = r_remem;
                        EV_CLICK: begin
                            go_steady  = 1'b1;
                            steady_lvl = r_remem;
                        end
                        EV_PRESS2:   n_cur = 8'd0;
                        EV_CLICK2, EV_CLICK_HOLD: begin
                            go_steady  = 1'b1;
                            steady_lvl = MAX_LVL;
                        end
                        EV_CLICK3:   n_ui = UI_STROBE;
                        EV_CLICK4:   n_ui = UI_BATT;
                        EV_HOLD: begin
                            if (r_in.arg >= {{(ARG_W-8){1'b0}}, r_hold}) begin
                                go_steady  = 1'b1;
                                steady_lvl = 8'd1;
                            end
                        end
                        EV_HOLD_REL: begin
                            go_steady  = 1'b1;
                            steady_lvl = 8'd1;
                        end
                        default:     n_handled = 1'b0;
                    endcase
                end
                UI_STEADY: begin
                    n_handled = 1'b1;
                    case (r_in.mode) inside
                        EV_CLICK:  go_off = 1'b1;
                        EV_CLICK2: begin
                            if (r_cur < MAX_LVL) begin
                                n_remem = r_cur;
                                n_tt    = MAX_LVL;
                                n_cur   = MAX_LVL;
                            end else begin
                                n_tt  = r_remem;
                                n_cur = r_remem;
                            end
                        end
                        EV_CLICK3: n_ui = UI_STROBE;
                        EV_CLICK4: begin
                            // toggle smooth and stepped ramping
                            n_ramp  = (r_ramp == 8'd1) ? LVL_DIV6 : 8'd1;
                            n_blink = BLINK_LONG;
                            n_cur   = r_remem;
                        end
                        EV_HOLD, EV_CLICK_HOLD: begin
                            // ramp only on ticks that are a multiple of the step
                            if (r_rem == 8'd0) begin
                                n_remem = nl_ramp;
                                n_tt    = nl_ramp;
                                n_cur   = nl_ramp;
                                if (nl_ramp != r_cur &&
                                    (nl_ramp == r_thr ||
                                     nl_ramp == ((r_in.mode == EV_HOLD) ? MAX_LVL : 8'd1))) begin
                                    n_blink = BLINK_SHORT;
                                end
                            end
                        end
                        EV_HOT: begin
                            if (r_cur > LVL_DIV4) begin
                                n_cur = nl_hot;
                            end
                        end
                        EV_COOL: begin
                            if (r_cur < r_tt) begin
                                n_cur = nl_cool;
                            end
                        end
                        default:   n_handled = 1'b0;
                    endcase
                end
                UI_STROBE: begin
                    n_handled = 1'b1;
                    case (r_in.mode)
                        EV_CLICK:  go_off = 1'b1;
                        EV_CLICK2: n_ss = ~r_ss;
                        EV_CLICK3: begin
                            go_steady  = 1'b1;
                            steady_lvl = r_remem;
                        end
                        EV_HOLD: begin
                            if (!r_in.arg[0] && r_sw > STROBE_WAIT_MIN) begin
                                n_sw = r_sw - 8'd1;
                            end
                        end
                        EV_CLICK_HOLD: begin
                            if (!r_in.arg[0] && r_sw < STROBE_WAIT_MAX) begin
                                n_sw = r_sw + 8'd1;
                            end
                        end
                        default:   n_handled = 1'b0;
                    endcase
                end
                UI_BATT: begin
                    if (r_in.mode == EV_CLICK) begin
                        go_off    = 1'b1;
                        n_handled = 1'b1;
                    end else if (r_in.mode == EV_CLICK2) begin
                        n_ui      = UI_TEMP;
                        n_handled = 1'b1;
                    end
                end
                UI_TEMP: begin
                    if (r_in.mode == EV_CLICK) begin
                        go_off    = 1'b1;
                        n_handled = 1'b1;
                    end
                end
                default: go_off = 1'b1;
            endcase
        end

        if (go_off) begin
            n_ui  = UI_OFF;
            n_cur = 8'd0;
        end
        if (go_steady) begin
            n_ui = UI_STEADY;
            if (steady_lvl > 8'd1 && steady_lvl < MAX_LVL) begin
                n_remem = steady_lvl;
            end
            n_tt  = steady_lvl;
            n_cur = steady_lvl;
        end
    end

    // sequencer, ui state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_thr       <= RST_BRIGHT_THRESHOLD;
            r_hold      <= RST_HOLD_DELAY;
            r_ui        <= UI_OFF;
            r_cur       <= 8'd0;
            r_remem     <= RST_BRIGHT_THRESHOLD;
            r_tt        <= 8'd0;
            r_ramp      <= 8'd1;
            r_sw        <= RST_STROBE_WAIT;
            r_ss        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_BRIGHT_THRESHOLD) begin
                    r_thr <= i_cfg_wdata;
                end else begin
                    r_hold <= i_cfg_wdata;
                end
            end

            // result leaves on a transfer, unless a new one is loaded in its place
            if (r_out_valid && !i_out_stall && r_state != S_EXEC) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_shift <= i_in_data.arg;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= n_rem;
                    r_shift <= {r_shift[ARG_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ARG_W - 1)) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // commit only once the previous result has gone
                    if (out_free) begin
                        r_ui    <= n_ui;
                        r_cur   <= n_cur;
                        r_remem <= n_remem;
                        r_tt    <= n_tt;
                        r_ramp  <= n_ramp;
                        r_sw    <= n_sw;
                        r_ss    <= n_ss;

                        r_out.level         <= n_cur;
                        r_out.ui_mode       <= n_ui;
                        r_out.handled       <= n_handled;
                        r_out.blink         <= n_blink;
                        r_out.strobe_kind   <= n_ss;
                        r_out.strobe_period <= n_sw;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ready only between events
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hdl/flbui_checker.sv
// port-level checker for the flashlight ui controller, bound to the top level
`include "flashlight_button_ui_controller_top_assert.svh"

module flbui_checker
    import flbui_pkg::*;
#(
    parameter int MAX_BRIGHT = 150
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    localparam logic [7:0] MAX_LVL = 8'(MAX_BRIGHT);

    // a stalled result holds
    `FLBUI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // an accepted event keeps the block busy in the next cycle
    `FLBUI_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // level never exceeds full brightness and the blink code is one of three
    `FLBUI_ASSERT_IMP(a_level_range, i_clk, i_rst_n, o_out_valid, o_out_data.level <= MAX_LVL && o_out_data.blink <= BLINK_LONG)

    // strobe delay stays within its limits
    `FLBUI_ASSERT_IMP(a_strobe_range, i_clk, i_rst_n, o_out_valid, o_out_data.strobe_period >= STROBE_WAIT_MIN)

endmodule

bind flashlight_button_ui_controller_top flbui_checker #(.MAX_BRIGHT(MAX_BRIGHT)) u_flbui_checker (.*);

### verif/tb_top.sv
// self-checking testbench for the one-button flashlight ui controller
`timescale 1ns / 100ps

module tb_top;
    import flbui_pkg::*;

    // brightness scale and its derived steps, matched to the block's parameter
    localparam int LVL_MAX     = 150;
    localparam int LVL_QUARTER = LVL_MAX / 4;
    localparam int LVL_SIXTH   = LVL_MAX / 6;

    // event codes that no mode listens to
    localparam logic [3:0] EV_SPARE_LO = 4'd13;
    localparam logic [3:0] EV_SPARE_HI = 4'd15;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer on either side
    localparam int LONG_HOLD    = 300;   // receiver hold-off while the sender keeps offering
    localparam int DRAIN_CYCLES = 40;    // wait after the last result so that stray results are caught
    localparam int PHASE_GOAL   = 60;    // consumed events per random phase
    localparam int NUM_PHASES   = 6;

    // everything the mode machine carries from one event to the next
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] level;
        logic [7:0] saved;
        logic [7:0] target;
        logic [7:0] step;
        logic [7:0] period;
        logic       tactical;
    } t_ui_ctx;

    // clock, reset and block ports; the driven inputs are known from time zero
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       ev_valid  = 1'b0;
    logic       ev_stall;
    t_in        ev_data   = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    t_out       res_data;
    logic       cfg_we    = 1'b0;
    logic       cfg_idx   = REG_BRIGHT_THRESHOLD;
    logic [7:0] cfg_wdata = '0;

    // register values as last written
    logic [7:0] thr_cfg;
    logic [7:0] hold_cfg;

    // dut_view follows accepted transfers, plan_view runs ahead as events are queued
    t_ui_ctx dut_view;
    t_ui_ctx plan_view;

    t_in  event_backlog[$];
    t_out result_due[$];

    int   errors          = 0;
    int   handled_planned = 0;
    logic hit_fast        = 1'b0;
    logic hit_slow        = 1'b0;
    int   send_idle_pct   = 38;
    int   recv_idle_pct   = 38;
    int   hold_asked      = 0;
    int   hold_done       = 0;
    int   stall_left      = 0;
    int   quiet_cycles    = 0;

    flashlight_button_ui_controller_top #(
        .MAX_BRIGHT(LVL_MAX)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (ev_valid),
        .o_in_stall  (ev_stall),
        .i_in_data   (ev_data),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_data  (res_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_ui_ctx ui_ctx_reset();
        t_ui_ctx c;
        c.mode     = UI_OFF;
        c.level    = '0;
        c.saved    = RST_BRIGHT_THRESHOLD;
        c.target   = '0;
        c.step     = 8'd1;
        c.period   = RST_STROBE_WAIT;
        c.tactical = 1'b0;
        return c;
    endfunction

    // steady mode entry; the memory only keeps levels strictly inside the range
    function automatic void enter_steady(inout t_ui_ctx c, input int lvl);
        logic [7:0] l8;
        l8 = lvl[7:0];
        c.mode = UI_STEADY;
        if (l8 > 1 && l8 < LVL_MAX) begin
            c.saved = l8;
        end
        c.target = l8;
        c.level  = l8;
    endfunction

    // one event through the mode machine, giving the result it must report
    function automatic void ui_step(inout t_ui_ctx c, input t_in ev, input logic [7:0] thr,
                                    input logic [7:0] hdly, output t_out r);
        int         cur;
        int         st;
        int         nl;
        int         arg;
        logic       used;
        logic [1:0] bl;
        cur  = c.level;
        st   = (c.step == 0) ? 1 : c.step;
        arg  = ev.arg;
        used = 1'b1;
        bl   = BLINK_NONE;
        if (ev.mode == EV_LOW_VOLT) begin
            // low voltage is taken in every mode
            if (c.mode == UI_STROBE) begin
                enter_steady(c, LVL_SIXTH);
            end else if (c.mode == UI_STEADY && c.level > 1) begin
                c.level = c.level >> 1;
            end else begin
                c.mode  = UI_OFF;
                c.level = '0;
            end
        end else begin
            case (c.mode)
                UI_OFF: begin
                    case (ev.mode)
                        EV_PRESS1:     c.level = 8'd1;
                        EV_RELEASE1:   c.level = c.saved;
                        EV_CLICK:      enter_steady(c, c.saved);
                        EV_PRESS2:     c.level = '0;
                        EV_CLICK2:     enter_steady(c, LVL_MAX);
                        EV_CLICK3:     c.mode = UI_STROBE;
                        EV_CLICK4:     c.mode = UI_BATT;
                        EV_HOLD: begin
                            if (arg >= hdly) begin
                                enter_steady(c, 1);
                            end
                        end
                        EV_HOLD_REL:   enter_steady(c, 1);
                        EV_CLICK_HOLD: enter_steady(c, LVL_MAX);
                        default:       used = 1'b0;
                    endcase
                end
                UI_STEADY: begin
                    case (ev.mode)
                        EV_CLICK: begin
                            c.mode  = UI_OFF;
                            c.level = '0;
                        end
                        EV_CLICK2: begin
                            // jump to full and back to the remembered level
                            if (cur < LVL_MAX) begin
                                c.saved  = cur[7:0];
                                c.target = 8'(LVL_MAX);
                                c.level  = 8'(LVL_MAX);
                            end else begin
                                c.target = c.saved;
                                c.level  = c.saved;
                            end
                        end
                        EV_CLICK3: c.mode = UI_STROBE;
                        EV_CLICK4: begin
                            c.step  = (c.step == 1) ? 8'(LVL_SIXTH) : 8'd1;
                            bl      = BLINK_LONG;
                            c.level = c.saved;
                        end
                        EV_HOLD, EV_CLICK_HOLD: begin
                            // ramp only on ticks that are a multiple of the step
                            if (arg % st == 0) begin
                                if (ev.mode == EV_HOLD) begin
                                    nl = (cur + st < LVL_MAX) ? cur + st : LVL_MAX;
                                end else begin
                                    nl = (cur > st) ? cur - st : 1;
                                end
                                c.saved  = nl[7:0];
                                c.target = nl[7:0];
                                if (nl != cur && (nl == thr ||
                                        nl == ((ev.mode == EV_HOLD) ? LVL_MAX : 1))) begin
                                    bl = BLINK_SHORT;
                                end
                                c.level = nl[7:0];
                            end
                        end
                        EV_HOT: begin
                            // step-down saturates at zero, then floors at a quarter
                            if (cur > LVL_QUARTER) begin
                                nl = (cur > arg) ? cur - arg : 0;
                                if (nl < LVL_QUARTER) begin
                                    nl = LVL_QUARTER;
                                end
                                c.level = nl[7:0];
                            end
                        end
                        EV_COOL: begin
                            if (cur < c.target) begin
                                nl = cur + (arg >> 1);
                                if (nl > c.target) begin
                                    nl = c.target;
                                end
                                c.level = nl[7:0];
                            end
                        end
                        default: used = 1'b0;
                    endcase
                end
                UI_STROBE: begin
                    case (ev.mode)
                        EV_CLICK: begin
                            c.mode  = UI_OFF;
                            c.level = '0;
                        end
                        EV_CLICK2: c.tactical = ~c.tactical;
                        EV_CLICK3: enter_steady(c, c.saved);
                        EV_HOLD: begin
                            if (!ev.arg[0] && c.period > STROBE_WAIT_MIN) begin
                                c.period = c.period - 8'd1;
                            end
                        end
                        EV_CLICK_HOLD: begin
                            if (!ev.arg[0] && c.period < STROBE_WAIT_MAX) begin
                                c.period = c.period + 8'd1;
                            end
                        end
                        default: used = 1'b0;
                    endcase
                end
                UI_BATT: begin
                    if (ev.mode == EV_CLICK) begin
                        c.mode  = UI_OFF;
                        c.level = '0;
                    end else if (ev.mode == EV_CLICK2) begin
                        c.mode = UI_TEMP;
                    end else begin
                        used = 1'b0;
                    end
                end
                UI_TEMP: begin
                    if (ev.mode == EV_CLICK) begin
                        c.mode  = UI_OFF;
                        c.level = '0;
                    end else begin
                        used = 1'b0;
                    end
                end
                default: begin
                    c.mode  = UI_OFF;
                    c.level = '0;
                    used    = 1'b0;
                end
            endcase
        end
        r.level         = c.level;
        r.ui_mode       = c.mode;
        r.handled       = used;
        r.blink         = bl;
        r.strobe_kind   = c.tactical;
        r.strobe_period = c.period;
    endfunction

    // argument mix: the extremes, small tick counts and the full range
    function automatic logic [15:0] pick_arg();
        case ($urandom_range(0, 9))
            0:          return 16'h0000;
            1:          return 16'hFFFF;
            2, 3, 4, 5: return 16'($urandom_range(0, 300));
            default:    return 16'($urandom);
        endcase
    endfunction

    // mostly tick counts the ramp actually acts on
    function automatic logic [15:0] ramp_arg();
        int st;
        st = (plan_view.step == 0) ? 1 : plan_view.step;
        if ($urandom_range(0, 9) < 7) begin
            return 16'(st * $urandom_range(0, 65535 / st));
        end
        return pick_arg();
    endfunction

    // queue an event and move the look-ahead copy of the machine along
    task automatic plan_event(input logic [3:0] m, input logic [15:0] a);
        t_in  ev;
        t_out r;
        ev.mode = m;
        ev.arg  = a;
        ui_step(plan_view, ev, thr_cfg, hold_cfg, r);
        if (r.handled) begin
            handled_planned++;
        end
        if (plan_view.period == STROBE_WAIT_MIN) begin
            hit_fast = 1'b1;
        end
        if (plan_view.period == STROBE_WAIT_MAX) begin
            hit_slow = 1'b1;
        end
        event_backlog.push_back(ev);
    endtask

    // random events shaped by the mode the machine will be in, with some noise
    task automatic plan_phase(input int goal);
        int          r;
        int          n;
        logic        faster;
        logic [3:0]  m;
        logic [15:0] a;
        handled_planned = 0;
        while (handled_planned < goal) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                plan_event(4'($urandom_range(EV_PRESS1, EV_SPARE_HI)), pick_arg());
            end else begin
                r = $urandom_range(0, 99);
                case (plan_view.mode)
                    UI_OFF: begin
                        if (r < 20) begin
                            plan_event(EV_CLICK, pick_arg());
                        end else if (r < 35) begin
                            // tick counts around the hold delay
                            a = $urandom_range(0, 1) ? 16'($urandom_range(0, hold_cfg + 2))
                                                     : pick_arg();
                            plan_event(EV_HOLD, a);
                        end else if (r < 50) begin
                            plan_event(EV_CLICK3, pick_arg());
                        end else if (r < 58) begin
                            plan_event(EV_CLICK4, pick_arg());
                        end else if (r < 66) begin
                            plan_event($urandom_range(0, 1) ? EV_CLICK2 : EV_CLICK_HOLD,
                                       pick_arg());
                        end else begin
                            plan_event(4'($urandom_range(EV_PRESS1, EV_LOW_VOLT)),
                                       pick_arg());
                        end
                    end
                    UI_STEADY: begin
                        if (r < 15) begin
                            // ramp one way for a while, across the threshold and the ends
                            n = $urandom_range(5, 40);
                            m = $urandom_range(0, 1) ? EV_HOLD : EV_CLICK_HOLD;
                            repeat (n) begin
                                plan_event(m, ramp_arg());
                            end
                        end else if (r < 40) begin
                            plan_event($urandom_range(0, 1) ? EV_HOLD : EV_CLICK_HOLD,
                                       ramp_arg());
                        end else if (r < 52) begin
                            plan_event(EV_HOT, $urandom_range(0, 1) ?
                                       16'($urandom_range(0, 120)) : pick_arg());
                        end else if (r < 64) begin
                            plan_event(EV_COOL, $urandom_range(0, 1) ?
                                       16'($urandom_range(0, 120)) : pick_arg());
                        end else if (r < 70) begin
                            plan_event(EV_CLICK4, pick_arg());
                        end else if (r < 76) begin
                            plan_event(EV_CLICK2, pick_arg());
                        end else if (r < 80) begin
                            plan_event(EV_LOW_VOLT, pick_arg());
                        end else if (r < 86) begin
                            plan_event(EV_CLICK, pick_arg());
                        end else if (r < 90) begin
                            plan_event(EV_CLICK3, pick_arg());
                        end else begin
                            plan_event(4'($urandom_range(EV_PRESS1, EV_LOW_VOLT)),
                                       pick_arg());
                        end
                    end
                    UI_STROBE: begin
                        if (r < 40) begin
                            // speed runs, heading for whichever delay limit is still unseen
                            n      = $urandom_range(10, 60);
                            faster = !hit_fast ? 1'b1 : (!hit_slow ? 1'b0
                                                                   : 1'($urandom_range(0, 1)));
                            m      = faster ? EV_HOLD : EV_CLICK_HOLD;
                            repeat (n) begin
                                a = pick_arg();
                                if ($urandom_range(0, 9) != 0) begin
                                    a[0] = 1'b0;
                                end
                                plan_event(m, a);
                            end
                        end else if (r < 50) begin
                            plan_event(EV_CLICK, pick_arg());
                        end else if (r < 60) begin
                            plan_event(EV_CLICK2, pick_arg());
                        end else if (r < 68) begin
                            plan_event(EV_CLICK3, pick_arg());
                        end else if (r < 72) begin
                            plan_event(EV_LOW_VOLT, pick_arg());
                        end else begin
                            plan_event($urandom_range(0, 1) ? EV_HOLD : EV_CLICK_HOLD,
                                       pick_arg());
                        end
                    end
                    UI_BATT: begin
                        if (r < 40) begin
                            plan_event(EV_CLICK2, pick_arg());
                        end else if (r < 70) begin
                            plan_event(EV_CLICK, pick_arg());
                        end else begin
                            plan_event(4'($urandom_range(EV_PRESS1, EV_SPARE_HI)),
                                       pick_arg());
                        end
                    end
                    default: begin
                        if (r < 50) begin
                            plan_event(EV_CLICK, pick_arg());
                        end else begin
                            plan_event(4'($urandom_range(EV_PRESS1, EV_SPARE_HI)),
                                       pick_arg());
                        end
                    end
                endcase
            end
        end
    endtask

    // both registers, one write per clock, only ever with nothing in flight
    task automatic write_regs(input logic [7:0] thr, input logic [7:0] hdly);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_BRIGHT_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge i_clk);
        cfg_idx   <= REG_HOLD_DELAY;
        cfg_wdata <= hdly;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        thr_cfg  = thr;
        hold_cfg = hdly;
    endtask

    // sampled on the falling edge so the rising-edge processes have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (event_backlog.size() != 0 || ev_valid || result_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // event driver: predicts on each accepted transfer, then offers the next event
    always @(posedge i_clk) begin : drive_events
        t_out r;
        if (!i_rst_n) begin
            ev_valid <= 1'b0;
        end else begin
            if (ev_valid && !ev_stall) begin
                ui_step(dut_view, ev_data, thr_cfg, hold_cfg, r);
                result_due.push_back(r);
            end
            // a stalled transfer keeps its payload untouched
            if (!(ev_valid && ev_stall)) begin
                if (event_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    ev_valid <= 1'b1;
                    ev_data  <= event_backlog.pop_front();
                end else begin
                    ev_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each transfer against the oldest prediction, drives stall
    always @(posedge i_clk) begin : watch_results
        t_out want;
        if (i_rst_n && res_valid && !res_stall) begin
            if (result_due.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, res_data);
                errors++;
            end else begin
                want = result_due.pop_front();
                check_field("level", want.level, res_data.level);
                check_field("ui_mode", want.ui_mode, res_data.ui_mode);
                check_field("handled", want.handled, res_data.handled);
                check_field("blink", want.blink, res_data.blink);
                check_field("strobe_kind", want.strobe_kind, res_data.strobe_kind);
                check_field("strobe_period", want.strobe_period, res_data.strobe_period);
            end
        end
        if (!i_rst_n) begin
            res_stall <= 1'b0;
        end else if (stall_left != 0) begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (hold_asked != hold_done) begin
            // long hold-off so the block backs up and stalls its input
            res_stall  <= 1'b1;
            stall_left <= LONG_HOLD;
            hold_done  <= hold_asked;
        end else begin
            res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (ev_valid && !ev_stall) || (res_valid && !res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL flashlight_button_ui_controller_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int         p;
        logic [7:0] thr;
        logic [7:0] hdly;
        dut_view  = ui_ctx_reset();
        plan_view = ui_ctx_reset();
        thr_cfg   = RST_BRIGHT_THRESHOLD;
        hold_cfg  = RST_HOLD_DELAY;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_regs(RST_BRIGHT_THRESHOLD, RST_HOLD_DELAY);

        // directed walk through every mode at the power-on settings
        plan_event(EV_PRESS1, 16'h0000);       // momentary lowest level
        plan_event(EV_RELEASE1, 16'h0000);     // remembered level shown
        plan_event(EV_PRESS2, 16'hFFFF);
        plan_event(EV_SPARE_LO, 16'hFFFF);     // unused code, ignored
        plan_event(EV_HOLD, 16'd23);           // one tick short of the hold delay
        plan_event(EV_HOLD, 16'd24);           // ramp starts at the lowest level
        plan_event(EV_HOLD, 16'hFFFF);
        plan_event(EV_CLICK_HOLD, 16'h0000);   // back down to the floor, short blink
        plan_event(EV_CLICK2, 16'h0000);       // jump to full
        plan_event(EV_HOT, 16'hFFFF);          // step-down past zero, clamped to a quarter
        plan_event(EV_COOL, 16'hFFFF);         // step-up limited to the thermal target
        plan_event(EV_SPARE_HI, 16'h0000);     // unused code in steady
        plan_event(EV_CLICK4, 16'h0000);       // discrete ramp, long blink
        plan_event(EV_HOLD, 16'd50);
        plan_event(EV_HOLD, 16'd7);            // not a multiple of the step
        plan_event(EV_CLICK4, 16'h0000);       // smooth ramp again
        plan_event(EV_LOW_VOLT, 16'h0000);     // halves the level
        plan_event(EV_CLICK3, 16'h0000);       // strobe
        plan_event(EV_CLICK2, 16'h0000);       // tactical strobe
        plan_event(EV_HOLD, 16'h0000);         // faster
        plan_event(EV_LOW_VOLT, 16'hFFFF);     // strobe drops to a sixth in steady
        plan_event(EV_CLICK, 16'h0000);        // off
        plan_event(EV_CLICK4, 16'h0000);       // battery check
        plan_event(EV_CLICK2, 16'h0000);       // temperature check
        plan_event(EV_LOW_VOLT, 16'h0000);     // low voltage from a check mode

        // random phases, each opened with both registers and the block idle
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            send_idle_pct = 38;
            recv_idle_pct = 38;
            case (p)
                0: begin
                    thr  = 8'd1;
                    hdly = 8'd0;
                end
                1: begin
                    thr  = 8'd254;
                    hdly = 8'd255;
                end
                2: begin
                    // flat-out stretch with no idling on either side
                    thr           = 8'($urandom_range(1, 254));
                    hdly          = 8'($urandom_range(0, 255));
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                3: begin
                    thr  = 8'd149;
                    hdly = 8'd1;
                end
                4: begin
                    thr  = 8'd2;
                    hdly = 8'd128;
                end
                default: begin
                    thr  = 8'($urandom_range(1, 254));
                    hdly = 8'($urandom_range(0, 255));
                end
            endcase
            write_regs(thr, hdly);
            if (p == 3) begin
                hold_asked++;
            end
            plan_phase(PHASE_GOAL);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS flashlight_button_ui_controller_top");
        end else begin
            $display("FAIL flashlight_button_ui_controller_top");
        end
        $finish;
    end

endmodule
